// ===== design/rpt_pkg.sv =====
package rpt_pkg;

    localparam int CHANNELS_DEF    = 3;
    localparam int COUNT_BITS_DEF  = 12;
    localparam int SAMPLE_BITS_DEF = 19;

    localparam int VAL_BITS    = 18;
    localparam int SUM_BITS    = 48;
    localparam int RSUM_BITS   = 26;
    localparam int RCOUNT_BITS = 8;
    localparam int MINW_BITS   = 12;

    localparam logic [11:0] MIN_WINDOW_RESET = 12'd50;
    localparam logic [7:0]  MIN_REPORT_RESET = 8'd50;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_WINDOW = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    localparam logic [0:0] ADDR_MIN_WINDOW = 1'b0;
    localparam logic [0:0] ADDR_MIN_REPORT = 1'b1;

    typedef struct packed {
        logic          start;
        logic [47:0]   dividend;
        logic [47:0]   divisor;
    } rpt_div_req_t;

endpackage

// ===== design/three_channel_rms_peak_tracker.sv =====
// Per-channel windowed RMS and peak meter. A sample transfer passes from acceptance
// to the next ready through the states S_SREAD, S_SMUL and S_SWRITE: read the
// channel entry from the state memory, square, add, write back. A window close
// walks the channels one at a time through a shared bit-serial divider and square
// root; a report close uses the divider alone. A rejected channel skips the
// divider. Each close gives one result transfer per channel in channel order,
// last on the final one, and waits while the result side holds off. The state
// memory is cleared by a pass over all channels after reset, during which no
// input is taken. Registers: min_window_samples at 0x0, min_report_windows at 0x4.
module three_channel_rms_peak_tracker
#(
    parameter int CHANNELS    = rpt_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS  = rpt_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = rpt_pkg::SAMPLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], channel[3:2], sample_value[SAMPLE_BITS+3:4], zero fill
    input  logic [((SAMPLE_BITS + 4 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // channel_res[1:0], rms[19:2], peak[37:20], valid_res[38], zero fill
    output logic [39:0] m_axis_tdata,
    // kind
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(CHANNELS - 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SREAD  = 4'd2;
    localparam logic [3:0] S_SMUL   = 4'd3;
    localparam logic [3:0] S_SWRITE = 4'd4;
    localparam logic [3:0] S_CREAD  = 4'd5;
    localparam logic [3:0] S_CSTART = 4'd6;
    localparam logic [3:0] S_CWAIT  = 4'd7;
    localparam logic [3:0] S_CEMIT  = 4'd8;
    localparam logic [3:0] S_COUT   = 4'd9;

    typedef struct packed {
        logic [47:0]            ssum;
        logic [COUNT_BITS-1:0]  scnt;
        logic [17:0]            wpk;
        logic [17:0]            hrms;
        logic [17:0]            hpk;
        logic [25:0]            rsum;
        logic [7:0]             rcnt;
        logic [17:0]            rpk;
    } entry_t;

    entry_t mem [CHANNELS];
    entry_t rd_reg;
    entry_t wr_data;
    logic   wr_en;
    logic [CH_BITS-1:0] rd_addr, wr_addr;

    logic [11:0] minw_reg;
    logic [7:0]  minr_reg;

    logic [3:0]  state_reg, state_next;
    logic [CH_BITS-1:0] ch_reg, ch_next;
    logic        rep_reg, rep_next;
    logic [SAMPLE_BITS-1:0] mag_reg, mag_next;
    logic [2*SAMPLE_BITS-1:0] sq_full;
    logic [47:0] sq_reg;
    logic        ok_reg, ok_next;
    entry_t      ent_reg, ent_next;

    logic        ov_reg;
    logic [39:0] od_reg;
    logic        ou_reg, ol_reg;

    rpt_pkg::rpt_div_req_t dreq;
    logic        ddone;
    logic [47:0] dres;

    logic [1:0]  in_cmd;
    logic [1:0]  in_ch;
    logic [SAMPLE_BITS-1:0] in_smp;
    logic [SAMPLE_BITS-1:0] in_mag;
    logic [48:0] ssum_add;
    logic [17:0] pk_sat;
    logic [17:0] r_sat;
    logic [26:0] rsum_add;

    assign in_cmd = s_axis_tdata[1:0];
    assign in_ch  = s_axis_tdata[3:2];
    assign in_smp = s_axis_tdata[SAMPLE_BITS+3:4];
    assign in_mag = in_smp[SAMPLE_BITS-1] ? (~in_smp + 1'b1) : in_smp;

    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr[2])
            rpt_pkg::ADDR_MIN_WINDOW: prdata = {20'd0, minw_reg};
            rpt_pkg::ADDR_MIN_REPORT: prdata = {24'd0, minr_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minw_reg <= rpt_pkg::MIN_WINDOW_RESET;
            minr_reg <= rpt_pkg::MIN_REPORT_RESET;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            if (paddr[2] == rpt_pkg::ADDR_MIN_WINDOW)
            begin
                minw_reg <= pwdata[11:0];
            end
            else
            begin
                minr_reg <= pwdata[7:0];
            end
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    rpt_divsqrt u_divsqrt
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (dreq),
        .sqrt_after (!rep_reg),
        .done       (ddone),
        .result     (dres)
    );

    assign sq_full = mag_reg * mag_reg;

    always_ff @(posedge clk)
    begin
        sq_reg <= 48'(sq_full);
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        rep_next   = rep_reg;
        mag_next   = mag_reg;
        ok_next    = ok_reg;
        ent_next   = ent_reg;
        rd_addr    = ch_reg;
        wr_addr    = ch_reg;
        wr_en      = 1'b0;
        wr_data    = ent_reg;
        dreq.start    = 1'b0;
        dreq.dividend = ent_reg.ssum;
        dreq.divisor  = 48'(ent_reg.scnt);
        ssum_add = {1'b0, ent_reg.ssum} + {1'b0, sq_reg};
        pk_sat   = (SAMPLE_BITS > 18 && (mag_reg >> 18) != '0) ? 18'h3FFFF : 18'(mag_reg);
        r_sat    = (dres[47:18] != '0) ? 18'h3FFFF : dres[17:0];
        rsum_add = {1'b0, ent_reg.rsum} + 27'(r_sat);
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
                ch_next = ch_reg + 1'b1;
                if (ch_reg == CH_LAST)
                begin
                    ch_next    = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (in_cmd == rpt_pkg::CMD_SAMPLE)
                    begin
                        if (32'(in_ch) < CHANNELS)
                        begin
                            ch_next    = CH_BITS'(in_ch);
                            mag_next   = in_mag;
                            state_next = S_SREAD;
                        end
                    end
                    else if (in_cmd == rpt_pkg::CMD_WINDOW || in_cmd == rpt_pkg::CMD_REPORT)
                    begin
                        rep_next   = (in_cmd == rpt_pkg::CMD_REPORT);
                        ch_next    = '0;
                        state_next = S_CREAD;
                    end
                end
            end
            S_SREAD:
            begin
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                ent_next   = rd_reg;
                state_next = S_SWRITE;
            end
            S_SWRITE:
            begin
                wr_en = 1'b1;
                if (pk_sat > ent_reg.wpk)
                begin
                    wr_data.wpk = pk_sat;
                end
                if (ent_reg.scnt != COUNT_MAX)
                begin
                    wr_data.ssum = ssum_add[48] ? 48'hFFFF_FFFF_FFFF : ssum_add[47:0];
                    wr_data.scnt = ent_reg.scnt + 1'b1;
                end
                state_next = S_IDLE;
            end
            S_CREAD:
            begin
                state_next = S_CSTART;
            end
            S_CSTART:
            begin
                ent_next = rd_reg;
                if (rep_reg)
                begin
                    ok_next = (rd_reg.rcnt != '0) && (rd_reg.rcnt >= minr_reg);
                end
                else
                begin
                    ok_next = (rd_reg.scnt != '0) && (32'(rd_reg.scnt) >= 32'(minw_reg));
                end
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                dreq.start = 1'b1;
                if (rep_reg)
                begin
                    dreq.dividend = 48'(ent_reg.rsum);
                    dreq.divisor  = 48'(ent_reg.rcnt);
                end
                if (!ok_reg)
                begin
                    dreq.start = 1'b0;
                    state_next = S_CEMIT;
                end
                else
                begin
                    state_next = S_COUT;
                end
            end
            S_COUT:
            begin
                if (ddone)
                begin
                    state_next = S_CEMIT;
                    if (!rep_reg)
                    begin
                        ent_next.hrms = r_sat;
                        ent_next.hpk  = ent_reg.wpk;
                        if (ent_reg.rcnt != 8'hFF)
                        begin
                            ent_next.rsum = rsum_add[26] ? 26'h3FF_FFFF : rsum_add[25:0];
                            ent_next.rcnt = ent_reg.rcnt + 1'b1;
                        end
                        if (ent_reg.wpk > ent_reg.rpk)
                        begin
                            ent_next.rpk = ent_reg.wpk;
                        end
                    end
                    else
                    begin
                        ent_next.rsum = 26'(r_sat);
                    end
                end
            end
            S_CEMIT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    wr_en   = 1'b1;
                    wr_data = ent_reg;
                    if (rep_reg)
                    begin
                        wr_data.rsum = '0;
                        wr_data.rcnt = '0;
                        wr_data.rpk  = '0;
                    end
                    else
                    begin
                        wr_data.ssum = '0;
                        wr_data.scnt = '0;
                        wr_data.wpk  = '0;
                    end
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_CREAD;
                    if (ch_reg == CH_LAST)
                    begin
                        ch_next    = '0;
                        state_next = S_IDLE;
                    end
                    rd_addr = ch_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ch_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            if (state_reg == S_CEMIT && (!ov_reg || m_axis_tready))
            begin
                ov_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rep_reg <= rep_next;
        mag_reg <= mag_next;
        ok_reg  <= ok_next;
        ent_reg <= ent_next;
        if (state_reg == S_CEMIT && (!ov_reg || m_axis_tready))
        begin
            ou_reg <= rep_reg;
            ol_reg <= (ch_reg == CH_LAST);
            if (rep_reg)
            begin
                od_reg <= {1'b0, ok_reg,
                           ok_reg ? ent_reg.rpk : 18'd0,
                           ok_reg ? ent_reg.rsum[17:0] : 18'd0,
                           2'(ch_reg)};
            end
            else
            begin
                od_reg <= {1'b0, ok_reg, ent_reg.hpk, ent_reg.hrms, 2'(ch_reg)};
            end
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

endmodule

// ===== design/rpt_divsqrt.sv =====
module rpt_divsqrt
(
    input  logic                clk,
    input  logic                rst_n,
    input  rpt_pkg::rpt_div_req_t req,
    input  logic                sqrt_after,
    output logic                done,
    output logic [47:0]         result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [47:0] quo_reg, quo_next;
    logic [48:0] rem_reg, rem_next;
    logic [47:0] den_reg, den_next;
    logic        sq_reg, sq_next;
    logic [49:0] srem_reg, srem_next;
    logic [24:0] root_reg, root_next;
    logic        done_reg, done_next;

    logic [48:0] rem_sh;
    logic [49:0] srem_sh;
    logic [49:0] trial;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        sq_next    = sq_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        rem_sh     = {rem_reg[47:0], quo_reg[47]};
        srem_sh    = {srem_reg[47:0], quo_reg[47:46]};
        trial      = {23'd0, root_reg, 2'b01};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    quo_next   = req.dividend;
                    den_next   = req.divisor;
                    rem_next   = '0;
                    step_next  = '0;
                    sq_next    = sqrt_after;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    quo_next = {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[46:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd47)
                begin
                    step_next = '0;
                    if (sq_reg)
                    begin
                        srem_next  = '0;
                        root_next  = '0;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SQRT:
            begin
                if (srem_sh >= trial)
                begin
                    srem_next = srem_sh - trial;
                    root_next = {root_reg[23:0], 1'b1};
                end
                else
                begin
                    srem_next = srem_sh;
                    root_next = {root_reg[23:0], 1'b0};
                end
                quo_next  = {quo_reg[45:0], 2'b00};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd23)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        sq_reg   <= sq_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign done   = done_reg;
    assign result = sq_reg ? {23'd0, root_reg} : quo_reg;

endmodule
